// ===== src/blc_pkg.sv =====
// Shared types and constants for the Bresenham line cell generator.
package blc_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = 2;

  typedef logic [CoordW-1:0] coord_t;

  // Classified line request, handed from the front to the back.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    logic   neg_x;
    logic   neg_y;
    logic   x_major;
    coord_t major;
    coord_t minor;
  } line_job_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

endpackage

// ===== src/blc_front.sv =====
// Front end: clamps request coordinates and derives deltas, directions and axis.
module blc_front import blc_pkg::*; #(
  parameter int unsigned GridSide = 64
) (
  input  logic [23:0] req_data_i,
  output line_job_t   job_o
);

  localparam coord_t CoordMax = CoordW'(GridSide - 1);

  coord_t x0, x1, y0, y1, dx, dy;
  logic   neg_x, neg_y, x_major;

  function automatic coord_t clamp(input coord_t v);
    clamp = (v > CoordMax) ? CoordMax : v;
  endfunction

  always_comb begin
    x0 = clamp(req_data_i[5:0]);
    x1 = clamp(req_data_i[11:6]);
    y0 = clamp(req_data_i[17:12]);
    y1 = clamp(req_data_i[23:18]);
    neg_x = x1 < x0;
    neg_y = y1 < y0;
    dx = neg_x ? (x0 - x1) : (x1 - x0);
    dy = neg_y ? (y0 - y1) : (y1 - y0);
    x_major = dx >= dy;
    job_o.x0      = x0;
    job_o.y0      = y0;
    job_o.neg_x   = neg_x;
    job_o.neg_y   = neg_y;
    job_o.x_major = x_major;
    job_o.major   = x_major ? dx : dy;
    job_o.minor   = x_major ? dy : dx;
  end

endmodule

// ===== src/blc_queue.sv =====
// Two-entry job queue between the front and the back.
module blc_queue import blc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_job_t push_data_i,
  input  logic      pop_i,
  output line_job_t head_o,
  output q_stat_t   stat_o
);

  line_job_t        head_q, head_d, tail_q, tail_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != QCntW'(QDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (do_pop) begin
      head_d = tail_q;
      cnt_d  = cnt_d - QCntW'(1);
    end
    if (do_push) begin
      if (cnt_d == '0) begin
        head_d = push_data_i;
      end else begin
        tail_d = push_data_i;
      end
      cnt_d = cnt_d + QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign head_o       = head_q;
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.full  = cnt_q == QCntW'(QDepth);
  assign stat_o.count = cnt_q;

endmodule

// ===== src/blc_back.sv =====
// Back end: steps the error accumulator and emits one cell per cycle while the output is taken.
module blc_back import blc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  line_job_t job_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output coord_t    cell_x_o,
  output coord_t    cell_y_o,
  output logic      last_o
);

  back_state_e state_q, state_d;
  line_job_t   job_q, job_d;
  coord_t      x_q, x_d, y_q, y_d, err_q, err_d, left_q, left_d;
  coord_t      ox_q, ox_d, oy_q, oy_d;
  logic        olast_q, olast_d, ovalid_q, ovalid_d;
  logic        fire, step_minor, step_x, step_y;
  logic [CoordW:0] sum;

  assign fire       = (state_q == ST_RUN) && (!ovalid_q || out_ready_i);
  assign sum        = {1'b0, err_q} + {1'b0, job_q.minor};
  assign step_minor = sum >= {1'b0, job_q.major};
  assign step_x     = job_q.x_major || step_minor;
  assign step_y     = !job_q.x_major || step_minor;

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    left_d   = left_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !out_ready_i;
    pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          x_d     = job_i.x0;
          y_d     = job_i.y0;
          err_d   = job_i.major >> 1;
          left_d  = job_i.major;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fire) begin
          ox_d     = x_q;
          oy_d     = y_q;
          olast_d  = left_q == '0;
          ovalid_d = 1'b1;
          if (left_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            left_d = left_q - CoordW'(1);
            err_d  = step_minor ? CoordW'(sum - {1'b0, job_q.major}) : sum[CoordW-1:0];
            if (step_x) begin
              x_d = job_q.neg_x ? (x_q - CoordW'(1)) : (x_q + CoordW'(1));
            end
            if (step_y) begin
              y_d = job_q.neg_y ? (y_q - CoordW'(1)) : (y_q + CoordW'(1));
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    x_q     <= x_d;
    y_q     <= y_d;
    err_q   <= err_d;
    left_q  <= left_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign cell_x_o    = ox_q;
  assign cell_y_o    = oy_q;
  assign last_o      = olast_q;

endmodule

// ===== src/bresenham_line_cells.sv =====
// Top level of the Bresenham line cell generator.
// One request (start and end cell) yields max(|dx|,|dy|)+1 cells, start to end, one per
// cycle while the output is taken, tlast on the end cell. Coordinates above GRID_SIDE-1
// are clamped first. Each request is loaded into the stepping unit before its first cell;
// a two-entry queue behind the input lets up to two more requests be taken while a line
// is still being drawn.
module bresenham_line_cells import blc_pkg::*; #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // start_x, end_x, start_y, end_y
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // cell_x, cell_y, 4'b0
  output logic        m_axis_tlast_o
);

  localparam coord_t CoordMax = CoordW'(GRID_SIDE - 1);

  line_job_t front_job, head_job;
  q_stat_t   q_stat;
  logic      pop;
  coord_t    cell_x, cell_y;

  blc_front #(.GridSide(GRID_SIDE)) u_front (
    .req_data_i (s_axis_tdata_i),
    .job_o      (front_job)
  );

  blc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .stat_o      (q_stat)
  );

  blc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cell_x_o    (cell_x),
    .cell_y_o    (cell_y),
    .last_o      (m_axis_tlast_o)
  );

  assign s_axis_tready_o = !q_stat.full;
  assign m_axis_tdata_o  = {4'b0, cell_y, cell_x};

`ifndef SYNTH
  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cell_x <= CoordMax) && (cell_y <= CoordMax))
    else $error("emitted cell outside grid");

  a_q_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCntW'(QDepth))
    else $error("queue count overflow");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (q_stat.count == QCntW'(QDepth)))
    else $error("input stalled with queue space");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== verif/bresenham_line_cells_tb.sv =====
// Self-checking testbench for the Bresenham line cell generator: line requests in, cells out.
`timescale 1ns / 100ps

module bresenham_line_cells_tb;
  import blc_pkg::*;

  localparam int GridSide   = 64;
  localparam int CycleLimit = 1000000;
  localparam int DrainCyc   = 200;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } cell_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_data = '0;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  cell_t cell_q[$];
  int    n_errors = 0;
  int    src_idle_pct = 19;
  int    sink_idle_pct = 65;
  int    cycles = 0;

  bresenham_line_cells #(.GRID_SIDE(GridSide)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > GridSide - 1) return GridSide - 1;
    return v;
  endfunction

  // Queue every cell of the line from (x0,y0) to (x1,y1).
  task automatic trace_line(coord_t sx0, coord_t sy0, coord_t sx1, coord_t sy1);
    int    x0, y0, x1, y1;
    int    dx, dy, stx, sty, major, minor, err, x, y;
    logic  x_major;
    cell_t c;
    x0 = clamp_coord(int'(sx0));
    y0 = clamp_coord(int'(sy0));
    x1 = clamp_coord(int'(sx1));
    y1 = clamp_coord(int'(sy1));
    dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
    stx = (x1 >= x0) ? 1 : -1;
    sty = (y1 >= y0) ? 1 : -1;
    x_major = (dx >= dy);
    major = x_major ? dx : dy;
    minor = x_major ? dy : dx;
    err = major / 2;
    x = x0;
    y = y0;
    for (int n = 0; n <= major; n++) begin
      c.x = coord_t'(x);
      c.y = coord_t'(y);
      c.last = (n == major);
      cell_q = {cell_q, c};
      err += minor;
      if (err >= major) begin
        err -= major;
        if (x_major) y += sty;
        else x += stx;
      end
      if (x_major) x += stx;
      else y += sty;
    end
  endtask

  // Entered and left just after a rising edge.
  task automatic send_line(int sx0, int sy0, int sx1, int sy1);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {coord_t'(sy1), coord_t'(sy0), coord_t'(sx1), coord_t'(sx0)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    trace_line(coord_t'(sx0), coord_t'(sy0), coord_t'(sx1), coord_t'(sy1));
  endtask

  task automatic test_single_cell();
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
  endtask

  task automatic test_axis_lines();
    send_line(0, 0, 63, 0);
    send_line(63, 0, 0, 0);
    send_line(0, 0, 0, 63);
    send_line(0, 63, 0, 0);
  endtask

  task automatic test_diagonals();
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    send_line(63, 0, 0, 63);
    send_line(0, 63, 63, 0);
  endtask

  task automatic test_octants();
    send_line(30, 30, 40, 33);
    send_line(30, 30, 33, 40);
    send_line(30, 30, 20, 33);
    send_line(30, 30, 27, 40);
    send_line(30, 30, 20, 27);
    send_line(30, 30, 27, 20);
    send_line(30, 30, 40, 27);
    send_line(30, 30, 33, 20);
  endtask

  task automatic test_near_lines();
    send_line(0, 0, 1, 0);
    send_line(7, 7, 9, 9);
    send_line(0, 0, 63, 1);
    send_line(0, 0, 62, 1);
  endtask

  task automatic send_rand_line();
    int kind, x0, y0, x1, y1;
    kind = $urandom_range(99);
    x0 = $urandom_range(63);
    y0 = $urandom_range(63);
    if (kind < 50) begin
      x1 = $urandom_range(63);
      y1 = $urandom_range(63);
    end else if (kind < 78) begin
      x1 = clamp_coord(x0 + int'($urandom_range(8)) - 4);
      y1 = clamp_coord(y0 + int'($urandom_range(8)) - 4);
    end else if (kind < 92) begin
      case ($urandom_range(2))
        0: begin
          x1 = $urandom_range(63);
          y1 = y0;
        end
        1: begin
          x1 = x0;
          y1 = $urandom_range(63);
        end
        default: begin
          x1 = clamp_coord(x0 + int'($urandom_range(20)) - 10);
          y1 = (y0 + (x1 - x0) >= 0 && y0 + (x1 - x0) <= 63) ? y0 + (x1 - x0)
                                                               : y0 - (x1 - x0);
        end
      endcase
    end else begin
      x1 = x0;
      y1 = y0;
    end
    send_line(x0, y0, x1, y1);
  endtask

  task automatic test_random_lines(int n_lines);
    for (int i = 0; i < n_lines; i++) send_rand_line();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cell_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (cell_q.size() == 0) begin
        $error("unexpected cell x=%0d y=%0d", m_axis_tdata_o[5:0], m_axis_tdata_o[11:6]);
        n_errors++;
      end else begin
        want = cell_q.pop_front();
        if (m_axis_tdata_o[5:0] !== want.x) begin
          $error("cell_x expected %0d actual %0d", want.x, m_axis_tdata_o[5:0]);
          n_errors++;
        end
        if (m_axis_tdata_o[11:6] !== want.y) begin
          $error("cell_y expected %0d actual %0d", want.y, m_axis_tdata_o[11:6]);
          n_errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_cell expected %0b actual %0b", want.last, m_axis_tlast_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_cell();
    test_axis_lines();
    test_diagonals();
    test_octants();
    test_near_lines();
    test_random_lines(130);
    src_idle_pct = 65;
    sink_idle_pct = 19;
    test_random_lines(130);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_lines(130);
    s_valid <= 1'b0;
    while (cell_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (n_errors == 0 && cell_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
